// ----- src/bmd_pkg.sv -----
// Shared types, opcodes and constants for the byte micro-program decryptor.
// Used by bmd_cfg_regs, bmd_cell and byte_microprogram_decryptor_unit.
// No dependencies.
`default_nettype none

package bmd_pkg;

    localparam int PROG_LEN_DEF = 36;
    localparam int STORE_BYTES  = 40;
    localparam int STORE_BITS   = STORE_BYTES * 8;
    localparam int CFG_BITS     = 296;

    localparam logic [7:0] OP_SKIP2   = 8'heb;
    localparam logic [7:0] OP_SKIP1   = 8'h0a;
    localparam logic [7:0] OP_NOP     = 8'h90;
    localparam logic [7:0] OP_CLC     = 8'hf8;
    localparam logic [7:0] OP_STC     = 8'hf9;
    localparam logic [7:0] OP_ADD_KEY = 8'h02;
    localparam logic [7:0] OP_SUB_KEY = 8'h2a;
    localparam logic [7:0] OP_XOR_KEY = 8'h32;
    localparam logic [7:0] OP_ADD_IMM = 8'h04;
    localparam logic [7:0] OP_SUB_IMM = 8'h2c;
    localparam logic [7:0] OP_XOR_IMM = 8'h34;
    localparam logic [7:0] OP_INC_DEC = 8'hfe;
    localparam logic [7:0] OP_ROTATE  = 8'hc0;
    localparam logic [7:0] MOD_UP     = 8'hc0;
    localparam logic [7:0] TERMINATOR = 8'haa;

    localparam logic [2:0] CFG_PROG_0 = 3'd0;
    localparam logic [2:0] CFG_PROG_1 = 3'd1;
    localparam logic [2:0] CFG_PROG_2 = 3'd2;
    localparam logic [2:0] CFG_PROG_3 = 3'd3;
    localparam logic [2:0] CFG_PROG_4 = 3'd4;

    localparam logic [1:0] ERR_OK     = 2'd0;
    localparam logic [1:0] ERR_OPCODE = 2'd1;
    localparam logic [1:0] ERR_LENGTH = 2'd2;

    typedef struct packed {
        logic [7:0] acc;
        logic [1:0] skip;
        logic       halt;
    } t_cell_state;

endpackage

`default_nettype wire

// ----- src/bmd_cfg_regs.sv -----
// Program store of the decryptor: five configuration registers, 37 program bytes.
// Depends on bmd_pkg.
`default_nettype none

module bmd_cfg_regs
    import bmd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [2:0]            i_cfg_index,
    input  wire logic [63:0]           i_cfg_data,
    output logic [STORE_BITS-1:0]      o_store
);

    logic [63:0] r_prog0, r_prog1, r_prog2, r_prog3;
    logic [39:0] r_prog4;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog0 <= '0;
            r_prog1 <= '0;
            r_prog2 <= '0;
            r_prog3 <= '0;
            r_prog4 <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PROG_0: r_prog0 <= i_cfg_data;
                CFG_PROG_1: r_prog1 <= i_cfg_data;
                CFG_PROG_2: r_prog2 <= i_cfg_data;
                CFG_PROG_3: r_prog3 <= i_cfg_data;
                CFG_PROG_4: r_prog4 <= i_cfg_data[39:0];
                default: ;
            endcase
        end
    end

    assign o_store = {{(STORE_BITS - CFG_BITS){1'b0}},
                      r_prog4, r_prog3, r_prog2, r_prog1, r_prog0};

endmodule

`default_nettype wire

// ----- src/bmd_cell.sv -----
// One cell of the decryptor chain: executes the opcode at its program position
// when the cursor lands there, otherwise counts down pending operand bytes.
// Depends on bmd_pkg.
`default_nettype none

module bmd_cell
    import bmd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire t_cell_state i_state,
    input  wire logic [7:0]  i_key,
    input  wire logic [7:0]  i_op,
    input  wire logic [7:0]  i_arg1,
    input  wire logic [7:0]  i_arg2,
    output logic             o_valid,
    output t_cell_state      o_state,
    output logic [7:0]       o_key
);

    logic        r_valid;
    t_cell_state r_state;
    logic [7:0]  r_key;
    t_cell_state n_state;
    logic [15:0] w_rot;
    logic [2:0]  w_amt;

    assign w_amt = i_arg2[2:0];

    always_comb begin
        n_state = i_state;
        w_rot   = '0;
        if (!i_state.halt && i_state.skip == 2'd0) begin
            case (i_op) inside
                OP_SKIP2: n_state.skip = 2'd2;
                OP_SKIP1: n_state.skip = 2'd1;
                OP_NOP, OP_CLC, OP_STC: ;
                OP_ADD_KEY: begin
                    n_state.acc  = i_state.acc + i_key;
                    n_state.skip = 2'd1;
                end
                OP_SUB_KEY: begin
                    n_state.acc  = i_state.acc - i_key;
                    n_state.skip = 2'd1;
                end
                OP_XOR_KEY: begin
                    n_state.acc  = i_state.acc ^ i_key;
                    n_state.skip = 2'd1;
                end
                OP_ADD_IMM: begin
                    n_state.acc  = i_state.acc + i_arg1;
                    n_state.skip = 2'd1;
                end
                OP_SUB_IMM: begin
                    n_state.acc  = i_state.acc - i_arg1;
                    n_state.skip = 2'd1;
                end
                OP_XOR_IMM: begin
                    n_state.acc  = i_state.acc ^ i_arg1;
                    n_state.skip = 2'd1;
                end
                OP_INC_DEC: begin
                    n_state.acc  = (i_arg1 == MOD_UP) ? i_state.acc + 8'd1
                                                      : i_state.acc - 8'd1;
                    n_state.skip = 2'd1;
                end
                OP_ROTATE: begin
                    if (i_arg1 == MOD_UP) begin
                        w_rot       = {i_state.acc, i_state.acc} << w_amt;
                        n_state.acc = w_rot[15:8];
                    end else begin
                        w_rot       = {i_state.acc, i_state.acc} >> w_amt;
                        n_state.acc = w_rot[7:0];
                    end
                    n_state.skip = 2'd2;
                end
                default: n_state.halt = 1'b1;
            endcase
        end else if (!i_state.halt) begin
            n_state.skip = i_state.skip - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_state <= n_state;
            r_key   <= i_key;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;
    assign o_key   = r_key;

endmodule

`default_nettype wire

// ----- src/byte_microprogram_decryptor_unit.sv -----
// Top level of the byte micro-program decryptor: program store and cell chain.
// Depends on bmd_pkg, bmd_cfg_regs and bmd_cell.
//
// The program is loaded through a write port (i_cfg_valid, o_cfg_ready,
// i_cfg_index, i_cfg_data); o_cfg_ready is always high and indexes above four
// are ignored. Each request on the input channel (i_valid, o_stall) carries a
// data byte and a key byte; each request on the output channel (o_valid,
// i_stall) carries the transformed byte and an error code.
// The data path is a chain of PROG_LEN cells, one per program byte, each a
// register stage; a request passes through all of them before o_valid rises.
// One request is accepted every cycle while o_stall is low. When the receiver
// stalls a valid result, the whole chain holds and o_stall rises in the same
// cycle.
// Reset clears all program registers to zero and empties the chain.
`default_nettype none

module byte_microprogram_decryptor_unit
    import bmd_pkg::*;
#(
    parameter int PROG_LEN = PROG_LEN_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic [7:0]  i_key_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_result_byte,
    output logic [1:0]       o_error_code
);

    logic [STORE_BITS-1:0] w_store;
    logic                  w_en;
    logic                  w_valid [0:PROG_LEN];
    t_cell_state           w_state [0:PROG_LEN];
    logic [7:0]            w_key   [0:PROG_LEN];
    t_cell_state           w_last;
    logic [7:0]            w_term;

    bmd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_store     (w_store)
    );

    assign w_en    = !w_valid[PROG_LEN] || !i_stall;
    assign o_stall = !w_en;

    assign w_valid[0] = i_valid;
    assign w_state[0] = '{acc: i_data_byte, skip: 2'd0, halt: 1'b0};
    assign w_key[0]   = i_key_byte;

    for (genvar k = 0; k < PROG_LEN; k++) begin : g_cell
        bmd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[k]),
            .i_state (w_state[k]),
            .i_key   (w_key[k]),
            .i_op    (w_store[k*8 +: 8]),
            .i_arg1  (w_store[(k+1)*8 +: 8]),
            .i_arg2  (w_store[(k+2)*8 +: 8]),
            .o_valid (w_valid[k+1]),
            .o_state (w_state[k+1]),
            .o_key   (w_key[k+1])
        );
    end

    assign w_last = w_state[PROG_LEN];
    assign w_term = w_store[PROG_LEN*8 +: 8];

    assign o_valid       = w_valid[PROG_LEN];
    assign o_result_byte = w_last.acc;

    always_comb begin
        if (w_last.halt) begin
            o_error_code = ERR_OPCODE;
        end else if (w_last.skip != 2'd0 || w_term != TERMINATOR) begin
            o_error_code = ERR_LENGTH;
        end else begin
            o_error_code = ERR_OK;
        end
    end

endmodule

`default_nettype wire
